### rtl/per_sender_sequence_gap_tracker_unit_defines.svh
// Assertion macros shared by the sequence gap tracker modules.
// No dependencies; included by the modules that carry assertions.
`ifndef PER_SENDER_SEQUENCE_GAP_TRACKER_UNIT_DEFINES_SVH
`define PER_SENDER_SEQUENCE_GAP_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSGT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PSGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

### rtl/psgt_pkg.sv
// Shared types and constants of the sequence gap tracker.
// No dependencies; imported by every module of the block except psgt_ram.
package psgt_pkg;

	localparam int NUM_SENDERS_DEF = 256;
	localparam int SID_IN_W        = 8;
	localparam int SEQ_W           = 8;
	localparam int CNT_W           = 32;

	typedef enum logic [1:0] {
		ACT_RX_VALID   = 2'd0,
		ACT_RX_INVALID = 2'd1,
		ACT_TX_DONE    = 2'd2,
		ACT_CLEAR      = 2'd3
	} action_t;

	// One accepted event
	typedef struct packed {
		action_t               action;
		logic [SID_IN_W-1:0]   node_id;
		logic [SEQ_W-1:0]      seq_num;
	} item_t;

	// Per-frame verdict from the sender table
	typedef struct packed {
		logic [SEQ_W-1:0] lost;
		logic             first;
	} frame_res_t;

endpackage

### rtl/psgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; reads return the old contents on a same-address write.
module psgt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and read-first registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/psgt_sender_table.sv
// Per-sender state: seen bits in flops, last sequence numbers in a RAM.
// Depends on psgt_pkg, psgt_ram and the assertion macro header.
`include "per_sender_sequence_gap_tracker_unit_defines.svh"

module psgt_sender_table import psgt_pkg::*; #(
	parameter int NUM_SENDERS = NUM_SENDERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [SID_IN_W-1:0] node_id,
	input  logic                valid_s1,
	input  item_t               item_s1,
	output frame_res_t          res
);

	localparam int SID_W = $clog2(NUM_SENDERS);
	localparam logic [SID_IN_W:0] NUM_SENDERS_L = (SID_IN_W+1)'(NUM_SENDERS);

	logic [NUM_SENDERS-1:0] seen_q;
	logic                   fwd_hit_s1;
	logic [SEQ_W-1:0]       fwd_seq_s1;
	logic [SEQ_W-1:0]       ram_rdata;
	logic [SID_W-1:0]       idx_s1;
	logic [SID_W-1:0]       idx_in;
	logic                   in_range_s1;
	logic                   is_frame_s1;
	logic                   is_clear_s1;
	logic                   wr_en;
	logic                   seen_now;
	logic [SEQ_W-1:0]       last_seq;
	logic [SEQ_W-1:0]       expected;

	assign idx_s1      = item_s1.node_id[SID_W-1:0];
	assign idx_in      = node_id[SID_W-1:0];
	assign in_range_s1 = {1'b0, item_s1.node_id} < NUM_SENDERS_L;
	assign is_frame_s1 = valid_s1 && (item_s1.action == ACT_RX_VALID);
	assign is_clear_s1 = valid_s1 && (item_s1.action == ACT_CLEAR);
	assign wr_en       = is_frame_s1 && in_range_s1;

	// last sequence table, read at accept, written when the frame resolves
	psgt_ram #(
		.WIDTH (SEQ_W),
		.DEPTH (NUM_SENDERS)
	) u_last_seq (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (item_s1.seq_num),
		.re    (accept),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

	// forward a write that lands on the same edge as the read of the same sender
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			fwd_hit_s1 <= wr_en && (idx_s1 == idx_in);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_seq_s1 <= item_s1.seq_num;
		end
	end

	// seen bits: cleared by reset and by a clear item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (is_clear_s1) begin
			seen_q <= '0;
		end else if (wr_en) begin
			seen_q[idx_s1] <= 1'b1;
		end
	end

	// gap computation for the item in stage 1
	always_comb begin
		seen_now  = in_range_s1 && seen_q[idx_s1];
		last_seq  = fwd_hit_s1 ? fwd_seq_s1 : ram_rdata;
		expected  = last_seq + SEQ_W'(1);
		res.lost  = (is_frame_s1 && seen_now) ? (item_s1.seq_num - expected) : '0;
		res.first = is_frame_s1 && in_range_s1 && !seen_now;
	end

	`PSGT_ASSERT_SAME(a_first_no_loss, clk, arst_n, res.first, res.lost == '0,
		"first frame of a sender reported a loss")
	`PSGT_ASSERT_NEXT(a_clear_seen, clk, arst_n, is_clear_s1, seen_q == '0,
		"seen bits not cleared by clear item")
	`PSGT_ASSERT_NEXT(a_write_sets_seen, clk, arst_n, wr_en, seen_q[$past(idx_s1)],
		"seen bit not set after frame")

endmodule

### rtl/psgt_counters.sv
// Statistics counters and the registered result of each item.
// Depends on psgt_pkg and the assertion macro header.
`include "per_sender_sequence_gap_tracker_unit_defines.svh"

module psgt_counters import psgt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  action_t          action_s1,
	input  frame_res_t       res,
	output logic             done,
	output logic [SEQ_W-1:0] lost_now,
	output logic             first_from_sender,
	output logic [CNT_W-1:0] rx_count,
	output logic [CNT_W-1:0] rx_invalid_count,
	output logic [CNT_W-1:0] drop_count,
	output logic [CNT_W-1:0] tx_count
);

	logic             done_q;
	logic [SEQ_W-1:0] lost_q;
	logic             first_q;
	logic [CNT_W-1:0] rx_q;
	logic [CNT_W-1:0] inv_q;
	logic [CNT_W-1:0] drop_q;
	logic [CNT_W-1:0] tx_q;

	// counters update as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			rx_q   <= '0;
			inv_q  <= '0;
			drop_q <= '0;
			tx_q   <= '0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				unique case (action_s1)
					ACT_RX_VALID: begin
						rx_q   <= rx_q + CNT_W'(1);
						drop_q <= drop_q + {{(CNT_W-SEQ_W){1'b0}}, res.lost};
					end
					ACT_RX_INVALID: begin
						inv_q <= inv_q + CNT_W'(1);
					end
					ACT_TX_DONE: begin
						tx_q <= tx_q + CNT_W'(1);
					end
					ACT_CLEAR: begin
						rx_q   <= '0;
						inv_q  <= '0;
						drop_q <= '0;
						tx_q   <= '0;
					end
					default: begin
						rx_q <= rx_q;
					end
				endcase
			end
		end
	end

	// per-item result fields
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			lost_q  <= res.lost;
			first_q <= res.first;
		end
	end

	assign done              = done_q;
	assign lost_now          = lost_q;
	assign first_from_sender = first_q;
	assign rx_count          = rx_q;
	assign rx_invalid_count  = inv_q;
	assign drop_count        = drop_q;
	assign tx_count          = tx_q;

	`PSGT_ASSERT_NEXT(a_result_follows, clk, arst_n, valid_s1, done_q,
		"item in stage 1 produced no result")
	`PSGT_ASSERT_NEXT(a_clear_zero, clk, arst_n, valid_s1 && (action_s1 == ACT_CLEAR),
		(rx_q == '0) && (inv_q == '0) && (drop_q == '0) && (tx_q == '0),
		"counters not zero after clear")
	`PSGT_ASSERT_NEXT(a_rx_step, clk, arst_n, valid_s1 && (action_s1 == ACT_RX_VALID),
		rx_q == ($past(rx_q) + CNT_W'(1)), "rx counter did not step by one")

endmodule

### rtl/per_sender_sequence_gap_tracker_unit.sv
// Top level of the per-sender sequence gap tracker.
// Depends on psgt_pkg, psgt_sender_table, psgt_counters and psgt_ram.

// One item is taken per clock whenever start is high; busy stays low. Each
// item yields one result after passing the input register (with the
// registered read of the last-sequence RAM beside it) and the result register;
// done is high for a single cycle and the result is taken at the edge that
// ends it; the receiver has no way to stall it. A frame from the same sender
// whose RAM write lands on the edge of the read is forwarded around the RAM.
// Result counters show the totals after the item's update.
module per_sender_sequence_gap_tracker_unit import psgt_pkg::*; #(
	parameter int NUM_SENDERS = NUM_SENDERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic [SID_IN_W-1:0] node_id,
	input  logic [SEQ_W-1:0]    seq_num,
	output logic                done,
	output logic [SEQ_W-1:0]    lost_now,
	output logic                first_from_sender,
	output logic [CNT_W-1:0]    rx_count,
	output logic [CNT_W-1:0]    rx_invalid_count,
	output logic [CNT_W-1:0]    drop_count,
	output logic [CNT_W-1:0]    tx_count
);

	logic       accept;
	logic       valid_s1;
	item_t      item_s1;
	frame_res_t res;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action  <= action_t'(action);
			item_s1.node_id <= node_id;
			item_s1.seq_num <= seq_num;
		end
	end

	psgt_sender_table #(
		.NUM_SENDERS (NUM_SENDERS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.node_id  (node_id),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.res      (res)
	);

	psgt_counters u_counters (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_s1          (valid_s1),
		.action_s1         (item_s1.action),
		.res               (res),
		.done              (done),
		.lost_now          (lost_now),
		.first_from_sender (first_from_sender),
		.rx_count          (rx_count),
		.rx_invalid_count  (rx_invalid_count),
		.drop_count        (drop_count),
		.tx_count          (tx_count)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the per-sender sequence gap tracker unit.
// Depends on psgt_pkg and the per_sender_sequence_gap_tracker_unit RTL.
module testbench;
	import psgt_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_REPORTS  = 10;

	// Expected contents of one result item
	typedef struct {
		logic [SEQ_W-1:0] lost;
		logic             first;
		logic [CNT_W-1:0] rx;
		logic [CNT_W-1:0] invalid;
		logic [CNT_W-1:0] drop;
		logic [CNT_W-1:0] tx;
	} gap_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic [1:0]          action    = ACT_RX_VALID;
	logic [SID_IN_W-1:0] node_id   = '0;
	logic [SEQ_W-1:0]    seq_num   = '0;
	logic                busy;
	logic                done;
	logic [SEQ_W-1:0]    lost_now;
	logic                first_from_sender;
	logic [CNT_W-1:0]    rx_count;
	logic [CNT_W-1:0]    rx_invalid_count;
	logic [CNT_W-1:0]    drop_count;
	logic [CNT_W-1:0]    tx_count;

	// Tracker state mirrored by the predictor
	bit               sender_seen [NUM_SENDERS_DEF];
	logic [SEQ_W-1:0] last_seq    [NUM_SENDERS_DEF];
	logic [CNT_W-1:0] rx_total;
	logic [CNT_W-1:0] invalid_total;
	logic [CNT_W-1:0] drop_total;
	logic [CNT_W-1:0] tx_total;

	gap_result_t expected_results[$];
	int          mismatch_cnt = 0;
	int          idle_pct     = 0;
	int          cycle_cnt    = 0;

	per_sender_sequence_gap_tracker_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.action            (action),
		.node_id           (node_id),
		.seq_num           (seq_num),
		.done              (done),
		.lost_now          (lost_now),
		.first_from_sender (first_from_sender),
		.rx_count          (rx_count),
		.rx_invalid_count  (rx_invalid_count),
		.drop_count        (drop_count),
		.tx_count          (tx_count)
	);

	always #CLK_HALF clk = ~clk;

	// Zero counters, seen bits and last sequences
	function automatic void clear_tracker();
		for (int i = 0; i < NUM_SENDERS_DEF; i++) begin
			sender_seen[i] = 1'b0;
			last_seq[i]    = '0;
		end
		rx_total      = '0;
		invalid_total = '0;
		drop_total    = '0;
		tx_total      = '0;
	endfunction

	// Apply one event to the mirrored state and return the result it shows
	function automatic gap_result_t track_event(action_t act, logic [SID_IN_W-1:0] sid,
			logic [SEQ_W-1:0] seq);
		gap_result_t      r;
		logic [SEQ_W-1:0] next_seq;
		r.lost  = '0;
		r.first = 1'b0;
		case (act)
			ACT_RX_VALID: begin
				rx_total = rx_total + 1;
				if (int'(sid) < NUM_SENDERS_DEF) begin
					if (sender_seen[sid]) begin
						next_seq   = last_seq[sid] + 8'd1;
						r.lost     = seq - next_seq;
						drop_total = drop_total + CNT_W'(r.lost);
					end else begin
						sender_seen[sid] = 1'b1;
						r.first          = 1'b1;
					end
					last_seq[sid] = seq;
				end
			end
			ACT_RX_INVALID: invalid_total = invalid_total + 1;
			ACT_TX_DONE:    tx_total = tx_total + 1;
			default:        clear_tracker();
		endcase
		r.rx      = rx_total;
		r.invalid = invalid_total;
		r.drop    = drop_total;
		r.tx      = tx_total;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [CNT_W-1:0] exp_v,
			logic [CNT_W-1:0] act_v);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t ns %s: expected %0h, got %0h", $time, what, exp_v, act_v);
	endtask

	// Offer one item, with random idle cycles first, and predict it on acceptance
	task automatic send_item(action_t act, logic [SID_IN_W-1:0] sid, logic [SEQ_W-1:0] seq);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		action  <= act;
		node_id <= sid;
		seq_num <= seq;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		expected_results.push_back(track_event(act, sid, seq));
	endtask

	// Hold off the sender until every expected result has come
	task automatic wait_for_results();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// First frames, in-order, gaps, repeats, wrap, ignored fields and clears
	task automatic test_directed();
		idle_pct = 0;
		send_item(ACT_RX_VALID,   8'h00, 8'h00);
		send_item(ACT_RX_VALID,   8'h00, 8'h01);
		send_item(ACT_RX_VALID,   8'h00, 8'h03);
		send_item(ACT_RX_VALID,   8'h00, 8'h03);
		send_item(ACT_RX_VALID,   8'hFF, 8'hFF);
		send_item(ACT_RX_VALID,   8'hFF, 8'h00);
		send_item(ACT_RX_VALID,   8'hFF, 8'hC8);
		send_item(ACT_RX_VALID,   8'h00, 8'h02);
		send_item(ACT_RX_INVALID, 8'hFF, 8'hFF);
		send_item(ACT_TX_DONE,    8'hFF, 8'hFF);
		send_item(ACT_RX_INVALID, 8'h00, 8'h00);
		send_item(ACT_TX_DONE,    8'h00, 8'h00);
		send_item(ACT_RX_VALID,   8'h01, 8'h80);
		send_item(ACT_RX_VALID,   8'h80, 8'h7F);
		send_item(ACT_RX_VALID,   8'h01, 8'h82);
		send_item(ACT_CLEAR,      8'hFF, 8'hFF);
		send_item(ACT_RX_VALID,   8'h00, 8'h07);
		send_item(ACT_RX_VALID,   8'hFF, 8'h09);
		send_item(ACT_CLEAR,      8'h00, 8'h00);
		send_item(ACT_CLEAR,      8'h55, 8'hAA);
		wait_for_results();
	endtask

	// Mostly well-formed per-sender streams with gaps, repeats and noise
	task automatic test_random_traffic(int n_items, int pct);
		logic [SID_IN_W-1:0] pool [4];
		logic [SID_IN_W-1:0] sid;
		logic [SEQ_W-1:0]    seq;
		action_t             act;
		int                  roll;
		int                  kind;
		idle_pct = pct;
		foreach (pool[i])
			pool[i] = SID_IN_W'($urandom);
		repeat (n_items) begin
			roll = $urandom_range(99);
			sid  = SID_IN_W'($urandom);
			seq  = SEQ_W'($urandom);
			if (roll < 72)
				act = ACT_RX_VALID;
			else if (roll < 84)
				act = ACT_RX_INVALID;
			else if (roll < 98)
				act = ACT_TX_DONE;
			else
				act = ACT_CLEAR;
			if (act == ACT_RX_VALID) begin
				if ($urandom_range(99) < 70)
					sid = pool[$urandom_range(3)];
				kind = $urandom_range(99);
				if (sender_seen[sid] && kind < 65)
					seq = last_seq[sid] + 8'd1;
				else if (sender_seen[sid] && kind < 80)
					seq = last_seq[sid] + SEQ_W'($urandom_range(2, 6));
				else if (sender_seen[sid] && kind < 85)
					seq = last_seq[sid];
			end
			send_item(act, sid, seq);
		end
		wait_for_results();
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		gap_result_t exp_r;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", '0, '0);
			end else begin
				exp_r = expected_results.pop_front();
				if (lost_now !== exp_r.lost)
					report_mismatch("lost_now", CNT_W'(exp_r.lost), CNT_W'(lost_now));
				if (first_from_sender !== exp_r.first)
					report_mismatch("first_from_sender", CNT_W'(exp_r.first),
						CNT_W'(first_from_sender));
				if (rx_count !== exp_r.rx)
					report_mismatch("rx_count", exp_r.rx, rx_count);
				if (rx_invalid_count !== exp_r.invalid)
					report_mismatch("rx_invalid_count", exp_r.invalid, rx_invalid_count);
				if (drop_count !== exp_r.drop)
					report_mismatch("drop_count", exp_r.drop, drop_count);
				if (tx_count !== exp_r.tx)
					report_mismatch("tx_count", exp_r.tx, tx_count);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		clear_tracker();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(345, 19);
		test_random_traffic(345, 52);
		test_random_traffic(345, 0);
		// anything still expected here never arrived
		mismatch_cnt += expected_results.size();
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
